// File: rtl/hsv_pkg.sv
package hsv_pkg;

	// field widths
	localparam int HUE_W = 13;
	localparam int PCT_W = 11;
	localparam int OUT_BITS = 16;

	// valid input ranges
	localparam int HUE_MAX = 5760;
	localparam int PCT_MAX = 1600;

	// hue units in one 60 degree sector
	localparam int SECTOR_UNITS = 960;
	localparam int T_W = 10;

	// per-channel weight: 960 * (1600 - s) + s * w, at most 1600 * 960
	localparam int A_W = 21;
	localparam int FULL_CHROMA = PCT_MAX * SECTOR_UNITS;

	// channel numerator v * a, at most 1600 * 1600 * 960
	localparam int NUM_W = 32;

	// common denominator 1600 * 1600 * 960 = 2^18 * 9375
	localparam int DIV_SHIFT = 18;
	localparam int DIV_ODD = 9375;
	localparam longint unsigned HALF_DENOM = 64'd1228800000;

	// scaling datapath widths
	localparam int Y_W = NUM_W + OUT_BITS;
	localparam int Z_W = OUT_BITS + 14;
	localparam int Q_W = OUT_BITS + 1;
	localparam int P_W = Q_W + 14;

	// reciprocal of 9375 applied to z >> EST_SHIFT, estimate low by at most one
	localparam int EST_SHIFT = 13;
	localparam int RECIP_SHIFT = OUT_BITS + 5;
	localparam int RECIP_W = OUT_BITS + 5;
	localparam longint unsigned RECIP = (64'd1 << (RECIP_SHIFT + EST_SHIFT)) / DIV_ODD;
	localparam int PROD_W = Q_W + RECIP_W;

	localparam longint unsigned OUT_MAX = (64'd1 << OUT_BITS) - 64'd1;

	// hue sectors of 60 degrees
	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} sector_t;

	// advance strobes, one per pipeline stage
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
	} stage_en_t;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [PCT_W-1:0] saturation;
		logic [PCT_W-1:0] brightness;
	} hsv_pix_t;

	typedef struct packed {
		logic [OUT_BITS-1:0] red;
		logic [OUT_BITS-1:0] green;
		logic [OUT_BITS-1:0] blue;
		logic invalid;
	} rgb_pix_t;

endpackage

// File: rtl/hsv_to_rgb_converter.sv
// channel  direction  payload      handshake
// hsv      in         hsv_pix_t    hsv_valid / hsv_stall
// rgb      out        rgb_pix_t    rgb_valid / rgb_stall
//
// one pixel per cycle sustained while rgb_stall is low; each result passes through stage registers s1 to s7
// the later stages hold the scaling path: multiply, reciprocal estimate, back-multiply, fix-up
// arst_n clears only the stage valid bits, the datapath registers hold no reset
// each stage takes new data when empty or when the stage after it moves,
// so bubbles close up and a stalled result holds while upstream stages fill
module hsv_to_rgb_converter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               hsv_valid,
	output logic               hsv_stall,
	input  hsv_pkg::hsv_pix_t  hsv_pix,
	output logic               rgb_valid,
	input  logic               rgb_stall,
	output hsv_pkg::rgb_pix_t  rgb_pix
);

	hsv_pkg::stage_en_t        en;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

	logic [hsv_pkg::PCT_W-1:0] s_s1;
	logic [hsv_pkg::PCT_W-1:0] v_s1;
	hsv_pkg::sector_t          sector_s1;
	logic [hsv_pkg::T_W-1:0]   t_s1;
	logic                      invalid_s1;

	logic [hsv_pkg::NUM_W-1:0] num_r_s3, num_g_s3, num_b_s3;
	logic invalid_s3, invalid_s4, invalid_s5, invalid_s6, invalid_s7;

	logic [hsv_pkg::OUT_BITS-1:0] red_s7, green_s7, blue_s7;

	// ready chain from the output back
	always_comb begin
		rdy7 = !valid_s7 || !rgb_stall;
		rdy6 = !valid_s6 || rdy7;
		rdy5 = !valid_s5 || rdy6;
		rdy4 = !valid_s4 || rdy5;
		rdy3 = !valid_s3 || rdy4;
		rdy2 = !valid_s2 || rdy3;
		rdy1 = !valid_s1 || rdy2;
		en.s1 = hsv_valid && rdy1;
		en.s2 = valid_s1 && rdy2;
		en.s3 = valid_s2 && rdy3;
		en.s4 = valid_s3 && rdy4;
		en.s5 = valid_s4 && rdy5;
		en.s6 = valid_s5 && rdy6;
		en.s7 = valid_s6 && rdy7;
	end

	assign hsv_stall = !rdy1;
	assign rgb_valid = valid_s7;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (rdy1) begin
				valid_s1 <= hsv_valid;
			end
			if (rdy2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy4) begin
				valid_s4 <= valid_s3;
			end
			if (rdy5) begin
				valid_s5 <= valid_s4;
			end
			if (rdy6) begin
				valid_s6 <= valid_s5;
			end
			if (rdy7) begin
				valid_s7 <= valid_s6;
			end
		end
	end

	// range flag alongside the scaling stages
	always_ff @(posedge clk) begin
		if (en.s4) begin
			invalid_s4 <= invalid_s3;
		end
		if (en.s5) begin
			invalid_s5 <= invalid_s4;
		end
		if (en.s6) begin
			invalid_s6 <= invalid_s5;
		end
		if (en.s7) begin
			invalid_s7 <= invalid_s6;
		end
	end

	hsv_sector u_sector (
		.clk        (clk),
		.en         (en),
		.pix        (hsv_pix),
		.s_s1       (s_s1),
		.v_s1       (v_s1),
		.sector_s1  (sector_s1),
		.t_s1       (t_s1),
		.invalid_s1 (invalid_s1)
	);

	hsv_chroma u_chroma (
		.clk        (clk),
		.en         (en),
		.s_s1       (s_s1),
		.v_s1       (v_s1),
		.sector_s1  (sector_s1),
		.t_s1       (t_s1),
		.invalid_s1 (invalid_s1),
		.num_r_s3   (num_r_s3),
		.num_g_s3   (num_g_s3),
		.num_b_s3   (num_b_s3),
		.invalid_s3 (invalid_s3)
	);

	hsv_scale u_scale_r (
		.clk    (clk),
		.en     (en),
		.num_s3 (num_r_s3),
		.q_s7   (red_s7)
	);

	hsv_scale u_scale_g (
		.clk    (clk),
		.en     (en),
		.num_s3 (num_g_s3),
		.q_s7   (green_s7)
	);

	hsv_scale u_scale_b (
		.clk    (clk),
		.en     (en),
		.num_s3 (num_b_s3),
		.q_s7   (blue_s7)
	);

	// result transaction
	always_comb begin
		rgb_pix.red = red_s7;
		rgb_pix.green = green_s7;
		rgb_pix.blue = blue_s7;
		rgb_pix.invalid = invalid_s7;
	end

	// an out-of-range pixel comes out black
	assert property (@(posedge clk) disable iff (!arst_n)
			rgb_valid && rgb_pix.invalid |->
			rgb_pix.red == '0 && rgb_pix.green == '0 && rgb_pix.blue == '0)
		else $error("invalid pixel with nonzero colour");

	// a result only appears when the stage before held a pixel
	assert property (@(posedge clk) disable iff (!arst_n)
			$rose(valid_s7) |-> $past(valid_s6))
		else $error("result without a pixel behind it");

endmodule

// File: rtl/hsv_sector.sv
module hsv_sector (
	input  logic                       clk,
	input  hsv_pkg::stage_en_t         en,
	input  hsv_pkg::hsv_pix_t          pix,
	output logic [hsv_pkg::PCT_W-1:0]  s_s1,
	output logic [hsv_pkg::PCT_W-1:0]  v_s1,
	output hsv_pkg::sector_t           sector_s1,
	output logic [hsv_pkg::T_W-1:0]    t_s1,
	output logic                       invalid_s1
);

	logic [hsv_pkg::HUE_W-1:0] base;
	logic [hsv_pkg::HUE_W-1:0] off;
	logic                      falling;
	hsv_pkg::sector_t          sector;
	logic [hsv_pkg::T_W-1:0]   t;
	logic                      invalid;

	// sector search, hue of exactly 360 lands in the last sector
	always_comb begin
		priority if (pix.hue >= hsv_pkg::HUE_W'(5 * hsv_pkg::SECTOR_UNITS)) begin
			sector = hsv_pkg::SEC_MAG_RED;
			base = hsv_pkg::HUE_W'(5 * hsv_pkg::SECTOR_UNITS);
			falling = 1'b1;
		end else if (pix.hue >= hsv_pkg::HUE_W'(4 * hsv_pkg::SECTOR_UNITS)) begin
			sector = hsv_pkg::SEC_BLU_MAG;
			base = hsv_pkg::HUE_W'(4 * hsv_pkg::SECTOR_UNITS);
			falling = 1'b0;
		end else if (pix.hue >= hsv_pkg::HUE_W'(3 * hsv_pkg::SECTOR_UNITS)) begin
			sector = hsv_pkg::SEC_CYN_BLU;
			base = hsv_pkg::HUE_W'(3 * hsv_pkg::SECTOR_UNITS);
			falling = 1'b1;
		end else if (pix.hue >= hsv_pkg::HUE_W'(2 * hsv_pkg::SECTOR_UNITS)) begin
			sector = hsv_pkg::SEC_GRN_CYN;
			base = hsv_pkg::HUE_W'(2 * hsv_pkg::SECTOR_UNITS);
			falling = 1'b0;
		end else if (pix.hue >= hsv_pkg::HUE_W'(hsv_pkg::SECTOR_UNITS)) begin
			sector = hsv_pkg::SEC_YEL_GRN;
			base = hsv_pkg::HUE_W'(hsv_pkg::SECTOR_UNITS);
			falling = 1'b1;
		end else begin
			sector = hsv_pkg::SEC_RED_YEL;
			base = '0;
			falling = 1'b0;
		end
	end

	// ramp weight of the secondary component within the sector
	always_comb begin
		off = pix.hue - base;
		if (falling) begin
			t = hsv_pkg::T_W'(hsv_pkg::HUE_W'(hsv_pkg::SECTOR_UNITS) - off);
		end else begin
			t = hsv_pkg::T_W'(off);
		end
		invalid = (pix.hue > hsv_pkg::HUE_W'(hsv_pkg::HUE_MAX)) ||
			(pix.saturation > hsv_pkg::PCT_W'(hsv_pkg::PCT_MAX)) ||
			(pix.brightness > hsv_pkg::PCT_W'(hsv_pkg::PCT_MAX));
	end

	// stage 1
	always_ff @(posedge clk) begin
		if (en.s1) begin
			s_s1 <= pix.saturation;
			v_s1 <= pix.brightness;
			sector_s1 <= sector;
			t_s1 <= t;
			invalid_s1 <= invalid;
		end
	end

endmodule

// File: rtl/hsv_chroma.sv
module hsv_chroma (
	input  logic                       clk,
	input  hsv_pkg::stage_en_t         en,
	input  logic [hsv_pkg::PCT_W-1:0]  s_s1,
	input  logic [hsv_pkg::PCT_W-1:0]  v_s1,
	input  hsv_pkg::sector_t           sector_s1,
	input  logic [hsv_pkg::T_W-1:0]    t_s1,
	input  logic                       invalid_s1,
	output logic [hsv_pkg::NUM_W-1:0]  num_r_s3,
	output logic [hsv_pkg::NUM_W-1:0]  num_g_s3,
	output logic [hsv_pkg::NUM_W-1:0]  num_b_s3,
	output logic                       invalid_s3
);

	typedef enum logic [1:0] {
		TERM_C,
		TERM_X,
		TERM_M
	} term_t;

	logic [hsv_pkg::PCT_W-1:0] s_diff;
	logic [hsv_pkg::A_W-1:0]   a_m;
	logic [hsv_pkg::A_W-1:0]   s_t;

	logic [hsv_pkg::A_W-1:0]   a_m_s2;
	logic [hsv_pkg::A_W-1:0]   a_x_s2;
	logic [hsv_pkg::PCT_W-1:0] v_s2;
	hsv_pkg::sector_t          sector_s2;
	logic                      invalid_s2;

	term_t                     sel_r, sel_g, sel_b;
	logic [hsv_pkg::A_W-1:0]   a_r, a_g, a_b;

	function automatic logic [hsv_pkg::A_W-1:0] pick(input term_t sel, input logic inv,
			input logic [hsv_pkg::A_W-1:0] ax, input logic [hsv_pkg::A_W-1:0] am);
		logic [hsv_pkg::A_W-1:0] res;
		unique case (sel)
			TERM_C:  res = hsv_pkg::A_W'(hsv_pkg::FULL_CHROMA);
			TERM_X:  res = ax;
			default: res = am;
		endcase
		if (inv) begin
			res = '0;
		end
		return res;
	endfunction

	// offset weight 960*(1600-s) and ramp weight s*t
	always_comb begin
		s_diff = hsv_pkg::PCT_W'(hsv_pkg::PCT_MAX) - s_s1;
		a_m = hsv_pkg::A_W'(s_diff) * hsv_pkg::A_W'(hsv_pkg::SECTOR_UNITS);
		s_t = hsv_pkg::A_W'(s_s1) * hsv_pkg::A_W'(t_s1);
	end

	// stage 2
	always_ff @(posedge clk) begin
		if (en.s2) begin
			a_m_s2 <= a_m;
			a_x_s2 <= a_m + s_t;
			v_s2 <= v_s1;
			sector_s2 <= sector_s1;
			invalid_s2 <= invalid_s1;
		end
	end

	// place chroma and ramp by sector
	always_comb begin
		unique case (sector_s2)
			hsv_pkg::SEC_RED_YEL: begin
				sel_r = TERM_C; sel_g = TERM_X; sel_b = TERM_M;
			end
			hsv_pkg::SEC_YEL_GRN: begin
				sel_r = TERM_X; sel_g = TERM_C; sel_b = TERM_M;
			end
			hsv_pkg::SEC_GRN_CYN: begin
				sel_r = TERM_M; sel_g = TERM_C; sel_b = TERM_X;
			end
			hsv_pkg::SEC_CYN_BLU: begin
				sel_r = TERM_M; sel_g = TERM_X; sel_b = TERM_C;
			end
			hsv_pkg::SEC_BLU_MAG: begin
				sel_r = TERM_X; sel_g = TERM_M; sel_b = TERM_C;
			end
			default: begin
				sel_r = TERM_C; sel_g = TERM_M; sel_b = TERM_X;
			end
		endcase
		// out-of-range pixels carry a zero numerator, which scales to zero
		a_r = pick(sel_r, invalid_s2, a_x_s2, a_m_s2);
		a_g = pick(sel_g, invalid_s2, a_x_s2, a_m_s2);
		a_b = pick(sel_b, invalid_s2, a_x_s2, a_m_s2);
	end

	// stage 3: scale weights by brightness
	always_ff @(posedge clk) begin
		if (en.s3) begin
			num_r_s3 <= hsv_pkg::NUM_W'(v_s2) * hsv_pkg::NUM_W'(a_r);
			num_g_s3 <= hsv_pkg::NUM_W'(v_s2) * hsv_pkg::NUM_W'(a_g);
			num_b_s3 <= hsv_pkg::NUM_W'(v_s2) * hsv_pkg::NUM_W'(a_b);
			invalid_s3 <= invalid_s2;
		end
	end

	// weights of a valid pixel never exceed full chroma
	assert property (@(posedge clk) en.s3 && !invalid_s2 |->
			a_x_s2 <= hsv_pkg::A_W'(hsv_pkg::FULL_CHROMA) &&
			a_m_s2 <= hsv_pkg::A_W'(hsv_pkg::FULL_CHROMA))
		else $error("chroma weight above full scale");

endmodule

// File: rtl/hsv_scale.sv
module hsv_scale (
	input  logic                          clk,
	input  hsv_pkg::stage_en_t            en,
	input  logic [hsv_pkg::NUM_W-1:0]     num_s3,
	output logic [hsv_pkg::OUT_BITS-1:0]  q_s7
);

	logic [hsv_pkg::Y_W-1:0]    y;
	logic [hsv_pkg::PROD_W-1:0] prod;
	logic [hsv_pkg::P_W-1:0]    rem_lim;
	logic [hsv_pkg::Q_W-1:0]    q_fix;

	logic [hsv_pkg::Z_W-1:0]    z_s4;
	logic [hsv_pkg::Z_W-1:0]    z_s5;
	logic [hsv_pkg::Q_W-1:0]    q_est_s5;
	logic [hsv_pkg::Z_W-1:0]    z_s6;
	logic [hsv_pkg::Q_W-1:0]    q_est_s6;
	logic [hsv_pkg::P_W-1:0]    p_s6;

	// num * (2^N - 1) + denom/2, then drop the power of two in the denominator
	always_comb begin
		y = (hsv_pkg::Y_W'(num_s3) << hsv_pkg::OUT_BITS) - hsv_pkg::Y_W'(num_s3) +
			hsv_pkg::Y_W'(hsv_pkg::HALF_DENOM);
	end

	// stage 4
	always_ff @(posedge clk) begin
		if (en.s4) begin
			z_s4 <= hsv_pkg::Z_W'(y >> hsv_pkg::DIV_SHIFT);
		end
	end

	// quotient estimate from the top bits of z
	always_comb begin
		prod = hsv_pkg::PROD_W'(z_s4[hsv_pkg::Z_W-1:hsv_pkg::EST_SHIFT]) *
			hsv_pkg::PROD_W'(hsv_pkg::RECIP);
	end

	// stage 5
	always_ff @(posedge clk) begin
		if (en.s5) begin
			q_est_s5 <= hsv_pkg::Q_W'(prod >> hsv_pkg::RECIP_SHIFT);
			z_s5 <= z_s4;
		end
	end

	// stage 6: back-multiply the estimate
	always_ff @(posedge clk) begin
		if (en.s6) begin
			p_s6 <= hsv_pkg::P_W'(q_est_s5) * hsv_pkg::P_W'(hsv_pkg::DIV_ODD);
			q_est_s6 <= q_est_s5;
			z_s6 <= z_s5;
		end
	end

	// one correction step, then clamp to full scale
	always_comb begin
		rem_lim = p_s6 + hsv_pkg::P_W'(hsv_pkg::DIV_ODD);
		q_fix = q_est_s6 + hsv_pkg::Q_W'(hsv_pkg::P_W'(z_s6) >= rem_lim);
	end

	// stage 7
	always_ff @(posedge clk) begin
		if (en.s7) begin
			if (q_fix > hsv_pkg::Q_W'(hsv_pkg::OUT_MAX)) begin
				q_s7 <= hsv_pkg::OUT_BITS'(hsv_pkg::OUT_MAX);
			end else begin
				q_s7 <= hsv_pkg::OUT_BITS'(q_fix);
			end
		end
	end

	// estimate is never high and at most one low
	assert property (@(posedge clk) en.s7 |->
			hsv_pkg::P_W'(z_s6) >= p_s6 &&
			hsv_pkg::P_W'(z_s6) - p_s6 < hsv_pkg::P_W'(2 * hsv_pkg::DIV_ODD))
		else $error("reciprocal estimate out of correction range");

endmodule
